[design/mpsp_pkg.sv]
// Shared constants and types for the PCM sample player.
`default_nettype none
package mpsp_pkg;
	localparam int CHANNELS = 16;
	localparam int CH_BITS = 4;
	localparam int ROM_ADDR_BITS = 20;
	localparam int REG_RAM_BYTES = 2048;
	localparam int REG_BITS = $clog2(REG_RAM_BYTES);
	localparam int ROM_BYTES = 1 << ROM_ADDR_BITS;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_LOAD  = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [2:0] CFG_BANK_SHIFT = 3'd0;
	localparam logic [2:0] CFG_BANK_MASK  = 3'd1;
	localparam logic [2:0] CFG_STEP       = 3'd2;
	localparam logic [2:0] CFG_A_GAIN     = 3'd3;
	localparam logic [2:0] CFG_A_DIR      = 3'd4;
	localparam logic [2:0] CFG_B_GAIN     = 3'd5;
	localparam logic [2:0] CFG_B_DIR      = 3'd6;

	// Signed mix sum: 16 channels of -128..127 times 0..255.
	typedef logic signed [23:0] mix_t;

	// Clamp a wide signed value to 16 bits.
	function automatic logic signed [15:0] clamp16(input logic signed [42:0] v);
		logic signed [15:0] r;
		if (v > 43'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -43'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Q8.8 scale, truncated toward zero.
	function automatic logic signed [41:0] scale_q88(input logic signed [40:0] p);
		logic [40:0] m;
		logic signed [41:0] r;
		m = p[40] ? (41'd0 - p) : p;
		r = {9'd0, m[40:8]};
		if (p[40]) begin
			r = 42'sd0 - r;
		end
		return r;
	endfunction
endpackage
`default_nettype wire

[design/mpsp_mixer.sv]
// Output routing: gain scaling, direction routing and clamping of the two sums.
`default_nettype none
module mpsp_mixer (
	input  wire logic clk,
	input  wire logic start,
	input  wire mpsp_pkg::mix_t lsum,
	input  wire mpsp_pkg::mix_t rsum,
	input  wire logic [15:0] a_gain,
	input  wire logic [1:0] a_dir,
	input  wire logic [15:0] b_gain,
	input  wire logic [1:0] b_dir,
	output logic signed [15:0] left,
	output logic signed [15:0] right
);
	logic signed [40:0] pa_s1, pb_s1;
	logic signed [41:0] a, b;
	logic signed [42:0] l, r;

	// Products registered before scaling and routing.
	always_ff @(posedge clk) begin
		if (start) begin
			pa_s1 <= 41'(lsum) * $signed({1'b0, a_gain});
			pb_s1 <= 41'(rsum) * $signed({1'b0, b_gain});
		end
	end

	always_comb begin
		a = mpsp_pkg::scale_q88(pa_s1);
		b = mpsp_pkg::scale_q88(pb_s1);
		l = '0;
		r = '0;
		if (a_dir[0]) l = l + 43'(a);
		if (a_dir[1]) r = r + 43'(a);
		if (b_dir[0]) l = l + 43'(b);
		if (b_dir[1]) r = r + 43'(b);
		left = mpsp_pkg::clamp16(l);
		right = mpsp_pkg::clamp16(r);
	end
endmodule
`default_nettype wire

[design/multichannel_pcm_sample_player.sv]
// Sixteen-channel PCM sample player: top level with register RAM, sample ROM and sequencer.
// Usage: items enter on in_valid/in_stall with operation and operand fields; each item
// gives exactly one result word on out_valid/out_stall. Configuration registers are
// written on cfg_valid/cfg_ready with cfg_index/cfg_data; the user must write them
// only while the block is idle; the block itself does not enforce this.
// A register write or read goes through a RAM access state and a wait state, a ROM load
// through a ROM write state, before its word. A tick walks the channels one by one
// through the register RAM port, which is the limit: each channel takes an address step,
// reads of its bytes in turn, a step for the last byte and the increment multiply, a
// shift, an update and three write backs. The next item can be taken once the word appears.
// After reset the register RAM is cleared to 0xFF by a pass over all 2048 bytes, one
// byte a cycle, during which no item is taken. Fractions are cleared by the same
// pass. The sample ROM is not cleared.
// One item is worked at a time. A finished word sits in the output register until
// taken; the next item is accepted while it waits, but its result stalls behind it
// and the input stalls until the waiting word is taken.
`default_nettype none
module multichannel_pcm_sample_player (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [1:0] operation,
	input  wire logic [10:0] reg_address,
	input  wire logic [7:0] reg_data,
	input  wire logic [19:0] rom_address,
	input  wire logic [7:0] rom_data,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [7:0] read_data,
	output logic signed [15:0] left_sample,
	output logic signed [15:0] right_sample,
	output logic sample_valid,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [23:0] cfg_data
);
	localparam int RB = mpsp_pkg::REG_BITS;
	localparam logic [4:0] S_CLEAR = 5'd0, S_IDLE = 5'd1, S_RD = 5'd2, S_RDW = 5'd3,
		S_CH = 5'd4, S_FETCH = 5'd5, S_LAST = 5'd6, S_MUL = 5'd7, S_ADV = 5'd8,
		S_W84 = 5'd9, S_W85 = 5'd10, S_W86 = 5'd11, S_MIX = 5'd12, S_OUT = 5'd13,
		S_ROM = 5'd14, S_DONE = 5'd15, S_RESULT = 5'd16;

	logic [7:0] ram [mpsp_pkg::REG_RAM_BYTES];
	logic [7:0] rom [mpsp_pkg::ROM_BYTES];
	logic [7:0] frac [mpsp_pkg::CHANNELS];
	logic [7:0] ram_q, rom_q;

	logic [4:0] state_q;
	logic [RB:0] clr_q;
	logic [1:0] op_q;
	logic [RB-1:0] ra_q;
	logic [7:0] wd_q;
	logic [mpsp_pkg::ROM_ADDR_BITS-1:0] rom_wa_q;
	logic [7:0] rom_wd_q;
	logic [mpsp_pkg::CH_BITS-1:0] ch_q;
	logic [3:0] k_q;
	logic [7:0] b_q [9];
	logic [23:0] addr_q;
	logic halt_q, skip_q;
	logic [31:0] inc_q;
	mpsp_pkg::mix_t ls_q, rs_q;
	logic [4:0] bshift_q;
	logic [7:0] bmask_q;
	logic [23:0] step_q;
	logic [15:0] again_q, bgain_q;
	logic [1:0] adir_q, bdir_q;
	logic signed [15:0] mix_l, mix_r;
	logic signed [15:0] lmix_q, rmix_q;
	logic [7:0] rd_q;
	logic tick_q;

	logic ram_we;
	logic [RB-1:0] ram_a;
	logic [7:0] ram_d;
	logic [RB-1:0] cbase;

	assign cbase = RB'({ch_q, 3'd0});

	// Byte offsets read per channel: 2..7, 0x84, 0x85, 0x86.
	function automatic logic [7:0] ch_off(input logic [3:0] k);
		logic [7:0] o;
		unique case (k)
			4'd6: o = 8'h84;
			4'd7: o = 8'h85;
			4'd8: o = 8'h86;
			default: o = 8'(k) + 8'd2;
		endcase
		return o;
	endfunction

	logic [23:0] next_addr, base_addr;
	logic [7:0] endp1;
	logic [31:0] rom_base;
	logic [mpsp_pkg::ROM_ADDR_BITS-1:0] rom_rd;

	always_comb begin
		logic [23:0] a;
		a = {b_q[7], b_q[6], frac[ch_q]};
		endp1 = b_q[4] + 8'd1;
		base_addr = a;
		if (a[23:16] == endp1 && !b_q[8][1]) begin
			base_addr = {b_q[3], b_q[2], 8'd0};
		end
		rom_base = 32'(b_q[8] & bmask_q) << bshift_q;
		rom_rd = mpsp_pkg::ROM_ADDR_BITS'(rom_base + 32'(base_addr[23:8]));
		next_addr = base_addr + inc_q[23:0];
	end

	always_comb begin
		ram_we = 1'b0;
		ram_a = ra_q;
		ram_d = wd_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_a = clr_q[RB-1:0];
				ram_d = 8'hff;
			end
			S_RD: begin
				ram_we = (op_q == mpsp_pkg::OP_WRITE);
			end
			S_CH, S_FETCH: begin
				ram_a = cbase + RB'(ch_off(k_q));
			end
			S_W84: begin
				ram_we = !skip_q;
				ram_a = cbase + RB'(8'h84);
				ram_d = halt_q ? b_q[6] : addr_q[15:8];
			end
			S_W85: begin
				ram_we = !skip_q;
				ram_a = cbase + RB'(8'h85);
				ram_d = halt_q ? b_q[7] : addr_q[23:16];
			end
			S_W86: begin
				ram_we = !skip_q && halt_q;
				ram_a = cbase + RB'(8'h86);
				ram_d = b_q[8] | 8'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ram_we) ram[ram_a] <= ram_d;
		ram_q <= ram[ram_a];
		if (state_q == S_ROM) rom[rom_wa_q] <= rom_wd_q;
		rom_q <= rom[rom_rd];
	end

	mpsp_mixer u_mix (
		.clk(clk), .start(state_q == S_MIX), .lsum(ls_q), .rsum(rs_q),
		.a_gain(again_q), .a_dir(adir_q), .b_gain(bgain_q), .b_dir(bdir_q),
		.left(mix_l), .right(mix_r)
	);

	assign in_stall = !(state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bshift_q <= 5'd16;
			bmask_q <= 8'd112;
			step_q <= 24'h010000;
			again_q <= 16'd256;
			adir_q <= 2'd1;
			bgain_q <= 16'd256;
			bdir_q <= 2'd2;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mpsp_pkg::CFG_BANK_SHIFT: bshift_q <= cfg_data[4:0];
				mpsp_pkg::CFG_BANK_MASK: bmask_q <= cfg_data[7:0];
				mpsp_pkg::CFG_STEP: step_q <= cfg_data;
				mpsp_pkg::CFG_A_GAIN: again_q <= cfg_data[15:0];
				mpsp_pkg::CFG_A_DIR: adir_q <= cfg_data[1:0];
				mpsp_pkg::CFG_B_GAIN: bgain_q <= cfg_data[15:0];
				mpsp_pkg::CFG_B_DIR: bdir_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
			op_q <= '0;
			ch_q <= '0;
			k_q <= '0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q < (RB+1)'(mpsp_pkg::CHANNELS)) frac[clr_q[3:0]] <= 8'd0;
					clr_q <= clr_q + 1'b1;
					if (clr_q == (RB+1)'(mpsp_pkg::REG_RAM_BYTES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q <= operation;
						ra_q <= reg_address[RB-1:0];
						wd_q <= reg_data;
						ch_q <= '0;
						k_q <= '0;
						ls_q <= '0;
						rs_q <= '0;
						unique case (operation)
							mpsp_pkg::OP_LOAD: state_q <= S_ROM;
							mpsp_pkg::OP_TICK: state_q <= S_CH;
							default: state_q <= S_RD;
						endcase
					end
				end
				S_ROM: state_q <= S_DONE;
				S_RD: state_q <= S_RDW;
				S_RDW: state_q <= S_DONE;
				S_CH: begin
					k_q <= k_q + 4'd1;
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					b_q[k_q - 4'd1] <= ram_q;
					if (k_q == 4'd8) begin
						state_q <= S_LAST;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_LAST: begin
					b_q[8] <= ram_q;
					inc_q <= 32'(b_q[5]) * 32'(step_q);
					state_q <= S_MUL;
				end
				S_MUL: begin
					inc_q <= inc_q >> 16;
					skip_q <= b_q[8][0];
					halt_q <= (base_addr[23:16] == endp1) && b_q[8][1];
					state_q <= S_ADV;
				end
				S_ADV: begin
					addr_q <= next_addr;
					if (!skip_q) begin
						if (halt_q) begin
							frac[ch_q] <= 8'd0;
						end else begin
							frac[ch_q] <= next_addr[7:0];
							ls_q <= ls_q + mpsp_pkg::mix_t'($signed({1'b0, rom_q}) - 9'sd128)
								* $signed({1'b0, b_q[0]});
							rs_q <= rs_q + mpsp_pkg::mix_t'($signed({1'b0, rom_q}) - 9'sd128)
								* $signed({1'b0, b_q[1]});
						end
					end
					state_q <= S_W84;
				end
				S_W84: state_q <= S_W85;
				S_W85: state_q <= S_W86;
				S_W86: begin
					k_q <= '0;
					if (ch_q == mpsp_pkg::CH_BITS'(mpsp_pkg::CHANNELS - 1)) begin
						state_q <= S_MIX;
					end else begin
						ch_q <= ch_q + 1'b1;
						state_q <= S_CH;
					end
				end
				S_MIX: state_q <= S_OUT;
				S_OUT: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid || !out_stall) state_q <= S_RESULT;
				end
				S_RESULT: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result word payload. The output ports change only when a new word is presented.
	always_ff @(posedge clk) begin
		if (state_q == S_RDW) rd_q <= (op_q == mpsp_pkg::OP_READ) ? ram_q : 8'd0;
		if (state_q == S_ROM) rd_q <= 8'd0;
		if (state_q == S_OUT) begin
			rd_q <= 8'd0;
			lmix_q <= mix_l;
			rmix_q <= mix_r;
		end
		if (state_q == S_IDLE && in_valid) begin
			tick_q <= (operation == mpsp_pkg::OP_TICK);
			rom_wa_q <= rom_address;
			rom_wd_q <= rom_data;
		end
		if (state_q == S_RESULT) begin
			read_data <= rd_q;
			sample_valid <= tick_q;
			left_sample <= tick_q ? lmix_q : 16'sd0;
			right_sample <= tick_q ? rmix_q : 16'sd0;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("item taken while busy");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) |=> out_valid)
		else $error("result word not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled word dropped");
endmodule
`default_nettype wire
